/* rtl/nsbe_pkg.sv */
// package for the nr short block encoder
// holds chunk constants, reed-muller basis rows, fsm codes and control structs
// no dependencies
package nsbe_pkg;

	localparam int CHUNK_WIDTH = 32;
	localparam int MAX_OUT_LEN_DEF = 2048;
	localparam int MSG_W = 11;
	localparam int NLEN_W = 4;
	localparam int QMOD_W = 4;
	localparam int ELEN_W = 12;
	localparam int CNT_W = 6;
	localparam int LEN_W = 6;
	localparam int ROT_W = 5;
	localparam int SPAN_W = 7;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 104;
	localparam int RM_ROWS_N = 11;

	// basis rows of the (32,11) code, bit j is code position j
	localparam logic [CHUNK_WIDTH-1:0] RM_ROWS [RM_ROWS_N] = '{
		32'hFFFF_FFFF,
		32'h4BA5_A933,
		32'h7D91_0E5A,
		32'h6D26_339C,
		32'h71C7_C3E0,
		32'h7E0F_FC00,
		32'h731D_8E64,
		32'h6B44_F5B0,
		32'h7DC2_18EC,
		32'h4DA1_B746,
		32'h42F0_FFFF
	};

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXPAND = 4'b0010,
		ST_EMIT   = 4'b0100,
		ST_ERR    = 4'b1000
	} nsbe_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic expand;
		logic emit;
		logic emit_err;
	} nsbe_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic req_bad;
		logic expand_done;
		logic last;
		logic out_free;
	} nsbe_sts_t;

	// ones in the n lowest bits, n up to the chunk width
	function automatic logic [CHUNK_WIDTH-1:0] low_mask(input logic [SPAN_W-1:0] n);
		logic [CHUNK_WIDTH-1:0] m;
		if (n >= SPAN_W'(CHUNK_WIDTH)) begin
			m = '1;
		end else begin
			m = (CHUNK_WIDTH'(1) << n) - CHUNK_WIDTH'(1);
		end
		return m;
	endfunction

	// chunk width modulo the base block length, for the lengths that occur
	function automatic logic [ROT_W-1:0] rot_of_len(input logic [LEN_W-1:0] len);
		logic [ROT_W-1:0] r;
		unique case (len)
			6'd3, 6'd6: r = 5'd2;
			6'd12, 6'd24: r = 5'd8;
			6'd18: r = 5'd14;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/nsbe_ctrl.sv */
// controller state machine of the nr short block encoder
// sequences load, pattern expansion and chunk transfers; uses nsbe_pkg
module nsbe_ctrl
	import nsbe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  nsbe_sts_t sts,
	output nsbe_cmd_t cmd
);

	nsbe_state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (sts.req_bad) begin
						state_d = ST_ERR;
					end else begin
						cmd.load = 1'b1;
						state_d = ST_EXPAND;
					end
				end
			end
			ST_EXPAND: begin
				if (sts.expand_done) begin
					state_d = ST_EMIT;
				end else begin
					cmd.expand = 1'b1;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last) state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.emit_err = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

/* rtl/nsbe_datapath.sv */
// datapath of the nr short block encoder
// request check, base block build, cyclic window and output register; uses nsbe_pkg
module nsbe_datapath
	import nsbe_pkg::*;
#(
	parameter int MAX_OUT_LENGTH = MAX_OUT_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	output logic                  m_tuser,
	input  nsbe_cmd_t             cmd,
	output nsbe_sts_t             sts
);

	localparam int REM_W = $clog2(MAX_OUT_LENGTH + 1);

	logic [MSG_W-1:0]  msg;
	logic [NLEN_W-1:0] nlen;
	logic [QMOD_W-1:0] qmod;
	logic [ELEN_W-1:0] elen;

	logic q_ok;
	logic [LEN_W-1:0] blk_len;
	logic req_bad;
	logic [CHUNK_WIDTH-1:0] b_val, b_fill, b_rep, used, rm_word;
	logic [CHUNK_WIDTH-1:0] c0, c1, c2;
	logic [ROT_W-1:0] q5;

	logic [CHUNK_WIDTH-1:0] w_val_q, w_fill_q, w_rep_q;
	logic [LEN_W-1:0] len_q;
	logic [ROT_W-1:0] rot_q;
	logic [SPAN_W-1:0] span_q;
	logic [REM_W-1:0] rem_q;

	logic [CNT_W-1:0] cnt;
	logic [CHUNK_WIDTH-1:0] cnt_mask, keep_lo;
	logic [LEN_W-1:0] sh_up;
	logic [CHUNK_WIDTH-1:0] n_val, n_fill, n_rep;

	logic m_tvalid_q, out_last_q, out_err_q;
	logic [CHUNK_WIDTH-1:0] out_val_q, out_fill_q, out_rep_q;
	logic [CNT_W-1:0] out_cnt_q;

	// input fields
	assign msg  = s_tdata[10:0];
	assign nlen = s_tdata[14:11];
	assign qmod = s_tdata[18:15];
	assign elen = s_tdata[30:19];
	assign q5   = {1'b0, qmod};

	// request check and base block length
	always_comb begin
		q_ok = (qmod == 4'd1) || (qmod == 4'd2) || (qmod == 4'd4) || (qmod == 4'd6)
			|| (qmod == 4'd8);
		if (nlen == 4'd1) begin
			blk_len = {2'b0, qmod};
		end else if (nlen == 4'd2) begin
			blk_len = ({2'b0, qmod} << 1) + {2'b0, qmod};
		end else begin
			blk_len = LEN_W'(CHUNK_WIDTH);
		end
		req_bad = (nlen == 4'd0) || (nlen > 4'd11) || ((nlen <= 4'd2) && !q_ok)
			|| (elen < {6'b0, blk_len}) || ({1'b0, elen} > 13'(MAX_OUT_LENGTH))
			|| (elen == '0);
	end

	// reed-muller word: xor of the rows selected by message bits below the message length
	always_comb begin
		rm_word = '0;
		for (int i = 0; i < RM_ROWS_N; i++) begin
			if (msg[i] && (NLEN_W'(i) < nlen)) rm_word = rm_word ^ RM_ROWS[i];
		end
	end

	// base block for the three message length classes
	always_comb begin
		c0 = CHUNK_WIDTH'(msg[0]);
		c1 = CHUNK_WIDTH'(msg[1]);
		c2 = CHUNK_WIDTH'(msg[0] ^ msg[1]);
		used = '0;
		b_val = rm_word;
		b_fill = '0;
		b_rep = '0;
		if (nlen == 4'd1) begin
			b_val = c0;
			b_rep = (qmod > 4'd1) ? CHUNK_WIDTH'(2) : '0;
			b_fill = low_mask({3'b0, qmod}) & ~CHUNK_WIDTH'(3);
		end else if (nlen == 4'd2) begin
			if (qmod == 4'd1) begin
				b_val = c0 | (c1 << 1) | (c2 << 2);
				used = CHUNK_WIDTH'(7);
			end else begin
				b_val = c0 | (c1 << 1) | (c2 << q5) | (c0 << (q5 + 5'd1))
					| (c1 << (q5 << 1)) | (c2 << ((q5 << 1) + 5'd1));
				used = CHUNK_WIDTH'(3) | (CHUNK_WIDTH'(1) << q5)
					| (CHUNK_WIDTH'(1) << (q5 + 5'd1)) | (CHUNK_WIDTH'(1) << (q5 << 1))
					| (CHUNK_WIDTH'(1) << ((q5 << 1) + 5'd1));
			end
			b_fill = low_mask({1'b0, blk_len}) & ~used;
		end
	end

	// chunk size and window advance by the chunk width modulo the block length
	always_comb begin
		cnt = (rem_q > REM_W'(CHUNK_WIDTH)) ? CNT_W'(CHUNK_WIDTH) : rem_q[CNT_W-1:0];
		cnt_mask = low_mask({1'b0, cnt});
		keep_lo = low_mask(SPAN_W'(CHUNK_WIDTH) - {2'b0, rot_q});
		sh_up = len_q - {1'b0, rot_q};
		n_val = ((w_val_q >> rot_q) & keep_lo) | ((w_val_q << sh_up) & ~keep_lo);
		n_fill = ((w_fill_q >> rot_q) & keep_lo) | ((w_fill_q << sh_up) & ~keep_lo);
		n_rep = ((w_rep_q >> rot_q) & keep_lo) | ((w_rep_q << sh_up) & ~keep_lo);
	end

	// window registers: load, double the filled span, then advance per chunk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_val_q <= b_val;
			w_fill_q <= b_fill;
			w_rep_q <= b_rep;
			len_q <= blk_len;
			rot_q <= rot_of_len(blk_len);
			span_q <= {1'b0, blk_len};
		end else if (cmd.expand) begin
			w_val_q <= w_val_q | (w_val_q << span_q);
			w_fill_q <= w_fill_q | (w_fill_q << span_q);
			w_rep_q <= w_rep_q | (w_rep_q << span_q);
			span_q <= span_q << 1;
		end else if (cmd.emit) begin
			w_val_q <= n_val;
			w_fill_q <= n_fill;
			w_rep_q <= n_rep;
		end
	end

	// positions still to send
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (cmd.load) begin
			rem_q <= elen[REM_W-1:0];
		end else if (cmd.emit) begin
			rem_q <= rem_q - REM_W'(cnt);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_err) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_val_q <= w_val_q & cnt_mask;
			out_fill_q <= w_fill_q & cnt_mask;
			out_rep_q <= w_rep_q & cnt_mask;
			out_cnt_q <= cnt;
			out_last_q <= (rem_q <= REM_W'(CHUNK_WIDTH));
			out_err_q <= 1'b0;
		end else if (cmd.emit_err) begin
			out_val_q <= '0;
			out_fill_q <= '0;
			out_rep_q <= '0;
			out_cnt_q <= '0;
			out_last_q <= 1'b1;
			out_err_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {2'b00, out_cnt_q, out_rep_q, out_fill_q, out_val_q};
	assign m_tlast = out_last_q;
	assign m_tuser = out_err_q;

	// status to the controller
	assign sts.req_bad = req_bad;
	assign sts.expand_done = (span_q >= SPAN_W'(CHUNK_WIDTH));
	assign sts.last = (rem_q <= REM_W'(CHUNK_WIDTH));
	assign sts.out_free = !m_tvalid_q || m_tready;

	// a chunk is only written into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_err) |-> (!m_tvalid_q || m_tready))
		else $error("chunk written over a pending transfer");

	// a data chunk is only sent while positions remain
	a_emit_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (rem_q != '0))
		else $error("chunk sent with nothing remaining");

	// an error result is a last, empty transfer
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_err_q) |-> (out_last_q && (out_cnt_q == '0)))
		else $error("error result carries data");

	// a data chunk holds one to a full chunk of positions
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !out_err_q) |->
		((out_cnt_q != '0) && (out_cnt_q <= CNT_W'(CHUNK_WIDTH))))
		else $error("chunk position count out of range");

endmodule

/* rtl/nr_short_block_encoder.sv */
// nr short block encoder: after the input transfer the controller loads the base block,
// doubles the window span up to five times for short base blocks, then writes the output register;
// ceil(E/32) chunks follow at one per cycle through the output register while m_tready is high
// a new input is taken once the last chunk is in the output register; one item at a time
// arst_n clears the controller, the output valid and the position counter; no clearing pass
module nr_short_block_encoder
	import nsbe_pkg::*;
#(
	parameter int MAX_OUT_LENGTH = MAX_OUT_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// message_bits[10:0], message_length[14:11], mod_order[18:15],
	// output_length[30:19], zero pad[31]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// coded_bits[31:0], fill_mask[63:32], repeat_mask[95:64], valid_count[101:96],
	// zero pad[103:102]
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	// request_error[0]
	output logic                  m_tuser
);

	nsbe_cmd_t cmd;
	nsbe_sts_t sts;

	// sequencing
	nsbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// block build and chunk output
	nsbe_datapath #(
		.MAX_OUT_LENGTH (MAX_OUT_LENGTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
